[rtl/itd_pkg.sv]
// Shared types, character codes and decimal weight table for the decimal ASCII converter.
package itd_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int NUM_POS   = 10;
  localparam int POS_W     = 4;
  localparam int WEIGHT_W  = 34;
  localparam int DIGIT_W   = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  localparam logic [POS_W-1:0] POS_TOP = POS_W'(NUM_POS - 1);

  localparam logic OP_SIGNED    = 1'b0;
  localparam logic OP_MAGNITUDE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;
    logic pos_zero;
  } status_t;

  // Weight k * 10^pos, for k in 1..9 and pos in 0..9.
  function automatic logic [WEIGHT_W-1:0] dec_mult(input logic [POS_W-1:0] pos,
                                                   input logic [DIGIT_W-1:0] k);
    logic [WEIGHT_W-1:0] kw;
    logic [WEIGHT_W-1:0] res;
    kw = WEIGHT_W'(k);
    case (pos)
      4'd0:    res = kw;
      4'd1:    res = WEIGHT_W'(34'd10) * kw;
      4'd2:    res = WEIGHT_W'(34'd100) * kw;
      4'd3:    res = WEIGHT_W'(34'd1000) * kw;
      4'd4:    res = WEIGHT_W'(34'd10000) * kw;
      4'd5:    res = WEIGHT_W'(34'd100000) * kw;
      4'd6:    res = WEIGHT_W'(34'd1000000) * kw;
      4'd7:    res = WEIGHT_W'(34'd10000000) * kw;
      4'd8:    res = WEIGHT_W'(34'd100000000) * kw;
      4'd9:    res = WEIGHT_W'(34'd1000000000) * kw;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[rtl/itd_ctrl.sv]
// Controller state machine that sequences the sign and digit positions of one item.
module itd_ctrl
  import itd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_op,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.emit_sign = 1'b0;
    cmd.step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (status.neg && (in_op == OP_SIGNED)) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.step = 1'b1;
        if (status.pos_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[rtl/itd_dp.sv]
// Datapath: magnitude register, decimal position counter, digit extraction and output register.
module itd_dp
  import itd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VALUE_W-1:0]  in_value,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  output logic [CHAR_W-1:0]   out_char_code,
  output logic                out_last
);

  logic [VALUE_W-1:0]  mag_r;
  logic [VALUE_W-1:0]  mag_nxt;
  logic [POS_W-1:0]    pos_r;
  logic                started_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   char_r;
  logic                last_r;

  logic [WEIGHT_W-1:0] weight [1:9];
  logic [9:1]          ge;
  logic [DIGIT_W-1:0]  digit;
  logic [WEIGHT_W-1:0] sub_w;
  logic [WEIGHT_W-1:0] mag_ext;
  logic [WEIGHT_W-1:0] diff;
  logic                emit_digit;

  // Absolute value of the input, formed modulo 2^32.
  assign mag_nxt = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;

  assign status.neg      = in_value[VALUE_W-1];
  assign status.pos_zero = (pos_r == '0);

  // Compare the magnitude against every multiple of the current decimal weight.
  assign mag_ext = WEIGHT_W'(mag_r);
  always_comb begin
    for (int k = 1; k <= 9; k++) begin
      weight[k] = dec_mult(pos_r, DIGIT_W'(k));
      ge[k]     = (mag_ext >= weight[k]);
    end
  end

  // The compares form a thermometer code; the highest set one is the digit.
  always_comb begin
    digit = '0;
    sub_w = '0;
    for (int k = 1; k <= 9; k++) begin
      if (ge[k]) begin
        digit = DIGIT_W'(k);
        sub_w = weight[k];
      end
    end
  end

  assign diff       = mag_ext - sub_w;
  assign emit_digit = (digit != '0) || started_r || (pos_r == '0);

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      pos_r     <= POS_TOP;
    end else if (cmd.load) begin
      started_r <= 1'b0;
      pos_r     <= POS_TOP;
    end else if (cmd.step) begin
      if (digit != '0) begin
        started_r <= 1'b1;
      end
      pos_r <= pos_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_nxt;
    end else if (cmd.step) begin
      mag_r <= diff[VALUE_W-1:0];
    end
  end

  // Output register: one item per strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign || (cmd.step && emit_digit);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= ASCII_MINUS;
      last_r <= 1'b0;
    end else if (cmd.step) begin
      char_r <= ASCII_ZERO + CHAR_W'(digit);
      last_r <= (pos_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule

[rtl/int_to_decimal_ascii.sv]
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
//   Channel | Ports                                 | Handshake
//   --------+---------------------------------------+----------------------------------
//   input   | start, busy, in_op, in_value          | taken when start && !busy
//   result  | out_valid, out_char_code, out_last    | one-cycle strobe, no back-pressure
//
// An item is loaded, then emits the minus sign if there is one, and then scans
// the ten decimal positions, one decimal position per cycle; a new item is taken
// only after the last position has been scanned.
// Characters leave the output register in the cycle after their position is scanned.
// Synchronous active-low reset returns the controller to idle and drops the strobe.
module int_to_decimal_ascii
  import itd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  output logic [CHAR_W-1:0]          out_char_code,
  output logic                       out_last
);

  cmd_t    cmd;
  status_t status;

  itd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

[rtl/itd_checker.sv]
// Port-level checker for the decimal ASCII converter and its bind to the top level.
module itd_checker
  import itd_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [CHAR_W-1:0]          out_char_code,
  input logic                       out_last
);

  // An accepted item keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // The final character of an item is never followed at once by another.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character right after the final one");

  // While characters remain to be sent, the block stays busy.
  a_busy_midway: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("block idle with characters pending");

  // The block goes idle exactly as it shows the final character.
  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> (out_valid && out_last))
    else $error("block went idle without a final character");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_char_code == ASCII_MINUS)) |-> !out_last)
    else $error("minus sign marked as final character");

endmodule

bind int_to_decimal_ascii itd_checker u_itd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the integer to decimal ASCII converter.
`timescale 1ns / 100ps

module testbench;
  import itd_pkg::*;

  // One expected character of a converted number.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  // Predicts the character stream of each accepted number and checks what comes out.
  class decimal_scoreboard;
    ascii_char_t expected_chars[$];
    int          errors;
    int          numbers_seen;
    int          negatives_seen;
    int          chars_checked;

    function new();
      errors         = 0;
      numbers_seen   = 0;
      negatives_seen = 0;
      chars_checked  = 0;
    endfunction

    // Converts one accepted number into its expected characters.
    function void note_item(logic op, logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [DIGIT_W-1:0] digits [NUM_POS];
      int                 nd;
      ascii_char_t        c;
      numbers_seen++;
      if (value[VALUE_W-1]) negatives_seen++;
      // The magnitude wraps in 32 bits, so the minimum value gives 2147483648.
      mag = value[VALUE_W-1] ? -value : value;
      nd  = 0;
      do begin
        digits[nd] = DIGIT_W'(mag % 10);
        mag        = mag / 10;
        nd++;
      end while (mag != 0 && nd < NUM_POS);
      // The minus sign appears only in signed mode.
      if (value[VALUE_W-1] && op == OP_SIGNED) begin
        c.code = ASCII_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        c.code = ASCII_ZERO + CHAR_W'(digits[k]);
        c.last = (k == 0);
        expected_chars.push_back(c);
      end
    endfunction

    // Compares one emitted character with the oldest expected one.
    function void check_char(logic [CHAR_W-1:0] code, logic last);
      ascii_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("character 0x%02h (last %0b) emitted with none expected", code, last);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      chars_checked++;
      if (code !== exp_c.code) begin
        $error("char_code: expected 0x%02h, actual 0x%02h", exp_c.code, code);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("last: expected %0b, actual %0b", exp_c.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_op = OP_SIGNED;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic [CHAR_W-1:0]         out_char_code;
  logic                      out_last;

  decimal_scoreboard sb = new();

  int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  // Clock with a 4 ns period.
  always #2 clk = ~clk;

  // Watch both channels at each rising edge, before the edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_item(in_op, in_value);
      if (out_valid === 1'b1) sb.check_char(out_char_code, out_last);
    end
  end

  // Offers one item after a random idle gap and holds it until it is taken.
  task automatic send_item(input logic op, input logic [VALUE_W-1:0] value, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic logic [VALUE_W-1:0] pow10(int p);
    logic [VALUE_W-1:0] r;
    r = 1;
    for (int i = 0; i < p; i++) r = r * 10;
    return r;
  endfunction

  // Random number shaped to cover every digit count, the sign and the extremes.
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int                 d;
    case ($urandom_range(0, 5))
      0, 5: v = $urandom();
      1: begin
        d = $urandom_range(1, NUM_POS);
        if (d == NUM_POS) v = $urandom_range(32'h7FFF_FFFF, pow10(NUM_POS - 1));
        else v = $urandom_range(pow10(d) - 1, (d == 1) ? 0 : pow10(d - 1));
      end
      2: v = $urandom_range(0, 20);
      3: v = pow10($urandom_range(0, NUM_POS - 1)) + $urandom_range(0, 2) - 1;
      default: begin
        if ($urandom_range(0, 1)) v = 32'h8000_0000 + $urandom_range(0, 3);
        else v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
    endcase
    if (v[VALUE_W-1] == 1'b0 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  localparam int NUM_DIRECTED = 12;
  localparam logic [VALUE_W-1:0] DIRECTED_VALUES [NUM_DIRECTED] = '{
    32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd99999, 32'd1000000000,
    -32'd999999999, 32'h7FFF_FFFF, -32'd2147483647, 32'h8000_0000
  };
  localparam int NUM_PHASES = 4;
  localparam int PHASE_IDLE [NUM_PHASES] = '{0, 85, 0, 34};
  localparam int ITEMS_PER_PHASE = 112;

  // Main sequence: reset, directed numbers, random phases, drain.
  initial begin
    int guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero, single digits, digit-count boundaries and both extremes in both modes.
    foreach (DIRECTED_VALUES[i]) begin
      send_item(OP_SIGNED, DIRECTED_VALUES[i], 0);
      send_item(OP_MAGNITUDE, DIRECTED_VALUES[i], 0);
    end

    // Random numbers, each phase with its own sender idle rate.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(logic'($urandom_range(0, 1)), random_value(), PHASE_IDLE[ph]);
      end
    end
    start <= 1'b0;

    // Let the last number drain, then give stray characters time to show.
    for (guard = 0; sb.pending() != 0 && guard < 2000; guard++) @(posedge clk);
    repeat (24) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected characters never arrived", sb.pending());
      sb.errors++;
    end
    $display("Converted %0d numbers (%0d negative) in both modes over %0d idle phases.",
             sb.numbers_seen, sb.negatives_seen, NUM_PHASES);
    $display("Checked %0d characters, %0d mismatches.", sb.chars_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit well beyond the slowest legal run.
  initial begin
    #(2_000_000);
    $display("timeout waiting for the converter");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
rtl/itd_pkg.sv
rtl/itd_ctrl.sv
rtl/itd_dp.sv
rtl/int_to_decimal_ascii.sv
rtl/itd_checker.sv
tb/sv/testbench.sv
